// ----- hw/rtl/fmr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmr_pkg: shared types and constants of the framed message receiver
// Parse phases, back-end states, status codes and the command word passed
// from the frame parser to the result emitter.
// ----------------------------------------------------------------------------
package fmr_pkg;

	localparam int STORE_DEPTH            = 32;
	localparam int STORE_AW               = 5;
	localparam int MAX_STORED_PAYLOAD_DEF = 32;
	localparam int CFG_DW                 = 64;
	localparam int CFG_IW                 = 3;

	localparam logic [CFG_IW-1:0] REG_START_MARKER = 3'd0;
	localparam logic [CFG_IW-1:0] REG_END_MARKER   = 3'd1;
	localparam logic [CFG_IW-1:0] REG_OPCODE_MASK0 = 3'd2;
	localparam logic [CFG_IW-1:0] REG_OPCODE_MASK1 = 3'd3;
	localparam logic [CFG_IW-1:0] REG_OPCODE_MASK2 = 3'd4;
	localparam logic [CFG_IW-1:0] REG_OPCODE_MASK3 = 3'd5;

	localparam logic [1:0] ST_GOOD   = 2'd0;
	localparam logic [1:0] ST_CKSUM  = 2'd1;
	localparam logic [1:0] ST_NO_END = 2'd2;

	typedef enum logic [2:0] {
		PH_HUNT,
		PH_OPCODE,
		PH_LENGTH,
		PH_PAYLOAD,
		PH_CHECKSUM,
		PH_END
	} phase_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_READ,
		BK_OUT
	} back_state_t;

	typedef struct packed {
		logic [7:0]   start_marker;
		logic [7:0]   end_marker;
		logic [255:0] opcode_mask;
	} cfg_t;

	typedef struct packed {
		logic [1:0] status;
		logic [7:0] opcode;
		logic [7:0] length;
		logic [5:0] count;
	} cmd_t;

	typedef struct packed {
		logic                we;
		logic [STORE_AW-1:0] addr;
		logic [7:0]          data;
	} mem_wr_t;

endpackage

// ----- hw/rtl/fmr_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmr_front: frame parser
// Hunts for the start marker, checks the opcode, tracks length and checksum,
// stores leading payload bytes and issues one command per finished frame.
// ----------------------------------------------------------------------------
module fmr_front import fmr_pkg::*; #(
	parameter int MAX_STORED_PAYLOAD = MAX_STORED_PAYLOAD_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] rx_byte,
	input  logic       back_busy,
	input  logic       cmd_full,
	output logic       cmd_push,
	output cmd_t       cmd,
	output mem_wr_t    mem_wr
);

	localparam int KEEP_CAP =
		(MAX_STORED_PAYLOAD > STORE_DEPTH) ? STORE_DEPTH : MAX_STORED_PAYLOAD;

	phase_t     ph_q, ph_d;
	logic [7:0] opcode_q;
	logic [7:0] length_q;
	logic [7:0] seen_q;
	logic [7:0] sum_q;
	logic       in_acc;
	logic       store;
	logic       op_ok;
	logic       sum_ok;
	logic [7:0] seen_nx;
	logic [5:0] keep_cnt;

	assign in_acc   = in_valid && in_ready;
	assign store    = (seen_q < 8'(KEEP_CAP));
	assign op_ok    = cfg.opcode_mask[rx_byte];
	assign sum_ok   = (8'(sum_q + cfg.end_marker) == rx_byte);
	assign seen_nx  = 8'(seen_q + 8'd1);
	assign keep_cnt = (length_q > 8'(KEEP_CAP)) ? 6'(KEEP_CAP) : length_q[5:0];

	always_comb begin
		ph_d = ph_q;
		if (in_acc) begin
			case (ph_q)
				PH_HUNT:     ph_d = (rx_byte == cfg.start_marker) ? PH_OPCODE : PH_HUNT;
				PH_OPCODE:   ph_d = op_ok ? PH_LENGTH : PH_HUNT;
				PH_LENGTH:   ph_d = (rx_byte != 8'd0) ? PH_PAYLOAD : PH_CHECKSUM;
				PH_PAYLOAD:  ph_d = (seen_nx == length_q) ? PH_CHECKSUM : PH_PAYLOAD;
				PH_CHECKSUM: ph_d = sum_ok ? PH_END : PH_HUNT;
				PH_END:      ph_d = PH_HUNT;
				default:     ph_d = PH_HUNT;
			endcase
		end
	end

	always_comb begin
		case (ph_q)
			PH_PAYLOAD:  in_ready = !(store && back_busy);
			PH_CHECKSUM: in_ready = !cmd_full;
			PH_END:      in_ready = !cmd_full;
			default:     in_ready = 1'b1;
		endcase
	end

	always_comb begin
		cmd_push    = 1'b0;
		cmd.status  = ST_GOOD;
		cmd.opcode  = opcode_q;
		cmd.length  = length_q;
		cmd.count   = 6'd0;
		mem_wr.we   = 1'b0;
		mem_wr.addr = seen_q[STORE_AW-1:0];
		mem_wr.data = rx_byte;
		case (ph_q)
			PH_PAYLOAD: begin
				mem_wr.we = in_acc && store;
			end
			PH_CHECKSUM: begin
				cmd_push   = in_acc && !sum_ok;
				cmd.status = ST_CKSUM;
			end
			PH_END: begin
				cmd_push = in_acc;
				if (rx_byte == cfg.end_marker) begin
					cmd.status = ST_GOOD;
					cmd.count  = keep_cnt;
				end else begin
					cmd.status = ST_NO_END;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q     <= PH_HUNT;
			opcode_q <= 8'd0;
			length_q <= 8'd0;
			seen_q   <= 8'd0;
			sum_q    <= 8'd0;
		end else begin
			ph_q <= ph_d;
			if (in_acc) begin
				case (ph_q)
					PH_OPCODE: begin
						if (op_ok) begin
							opcode_q <= rx_byte;
						end
					end
					PH_LENGTH: begin
						length_q <= rx_byte;
						seen_q   <= 8'd0;
						sum_q    <= 8'(cfg.start_marker + opcode_q + rx_byte);
					end
					PH_PAYLOAD: begin
						seen_q <= seen_nx;
						sum_q  <= 8'(sum_q + rx_byte);
					end
					default: ;
				endcase
			end
		end
	end

endmodule

// ----- hw/rtl/fmr_cmd_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmr_cmd_fifo: command queue
// Two-entry queue of frame commands between the parser and the emitter.
// ----------------------------------------------------------------------------
module fmr_cmd_fifo import fmr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t wr_cmd,
	input  logic pop,
	output cmd_t rd_cmd,
	output logic full,
	output logic empty
);

	cmd_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	assign full   = (cnt_q == 2'd2);
	assign empty  = (cnt_q == 2'd0);
	assign rd_cmd = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= 2'(cnt_q + {1'b0, push} - {1'b0, pop});
		end
	end

endmodule

// ----- hw/rtl/fmr_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmr_back: result emitter
// Holds the payload store, takes commands from the queue and emits one
// result per stored byte, or a single result for empty or failed frames.
// ----------------------------------------------------------------------------
module fmr_back import fmr_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  mem_wr_t             mem_wr,
	input  cmd_t                cmd,
	input  logic                cmd_empty,
	output logic                cmd_pop,
	output logic                busy,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [1:0]          status,
	output logic [7:0]          frame_opcode,
	output logic [7:0]          frame_length,
	output logic [STORE_AW-1:0] byte_index,
	output logic [7:0]          payload_byte,
	output logic                last
);

	logic [7:0]          mem [STORE_DEPTH];
	logic [7:0]          rd_q;
	back_state_t         st_q, st_d;
	cmd_t                cmd_q;
	logic [STORE_AW-1:0] idx_q;
	logic                no_data;
	logic                out_acc;

	assign no_data = (cmd_q.count == 6'd0);
	assign out_acc = out_valid && out_ready;

	always_comb begin
		st_d = st_q;
		case (st_q)
			BK_IDLE: begin
				if (!cmd_empty) begin
					st_d = (cmd.count == 6'd0) ? BK_OUT : BK_READ;
				end
			end
			BK_READ: st_d = BK_OUT;
			BK_OUT: begin
				if (out_acc) begin
					st_d = last ? BK_IDLE : BK_READ;
				end
			end
			default: st_d = BK_IDLE;
		endcase
	end

	always_comb begin
		cmd_pop      = (st_q == BK_IDLE) && !cmd_empty;
		busy         = (st_q != BK_IDLE);
		out_valid    = (st_q == BK_OUT);
		status       = cmd_q.status;
		frame_opcode = cmd_q.opcode;
		frame_length = cmd_q.length;
		byte_index   = idx_q;
		payload_byte = no_data ? 8'd0 : rd_q;
		last         = no_data || ({1'b0, idx_q} == 6'(cmd_q.count - 6'd1));
	end

	always_ff @(posedge clk) begin
		if (mem_wr.we) begin
			mem[mem_wr.addr] <= mem_wr.data;
		end
		if (st_q == BK_READ) begin
			rd_q <= mem[idx_q];
		end
		if (cmd_pop) begin
			cmd_q <= cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= BK_IDLE;
			idx_q <= '0;
		end else begin
			st_q <= st_d;
			if (cmd_pop) begin
				idx_q <= '0;
			end else if (out_acc && !last) begin
				idx_q <= STORE_AW'(idx_q + 1'b1);
			end
		end
	end

endmodule

// ----- hw/rtl/framed_message_receiver_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// framed_message_receiver_core: byte-stream deframer with additive checksum
// Parses start/opcode/length/payload/checksum/end frames from a byte stream
// and emits the stored payload, or one error result, per frame.
//
//   channel   direction  handshake               payload
//   input     in         in_valid / in_ready     rx_byte
//   output    out        out_valid / out_ready   status .. last
//   config    in         cfg_we                  cfg_index, cfg_data
//
// The parser takes one byte per cycle when not stalled.
// The emitter reads each stored byte from the store, then presents it as a result.
// Payload bytes that go to the store wait while an earlier frame is queued or emitted.
// Checksum and end bytes wait while the two-entry command queue is full.
// Reset returns to hunting; the payload store is not cleared.
// ----------------------------------------------------------------------------
module framed_message_receiver_core import fmr_pkg::*; #(
	parameter int MAX_STORED_PAYLOAD = MAX_STORED_PAYLOAD_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [7:0]          rx_byte,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [1:0]          status,
	output logic [7:0]          frame_opcode,
	output logic [7:0]          frame_length,
	output logic [STORE_AW-1:0] byte_index,
	output logic [7:0]          payload_byte,
	output logic                last,
	input  logic                cfg_we,
	input  logic [CFG_IW-1:0]   cfg_index,
	input  logic [CFG_DW-1:0]   cfg_data
);

	cfg_t    cfg_q;
	cmd_t    push_cmd;
	cmd_t    pop_cmd;
	mem_wr_t mem_wr;
	logic    cmd_push;
	logic    cmd_pop;
	logic    cmd_full;
	logic    cmd_empty;
	logic    back_busy;
	logic    busy_any;

	assign busy_any = back_busy || !cmd_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_marker <= 8'd2;
			cfg_q.end_marker   <= 8'd3;
			cfg_q.opcode_mask  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_START_MARKER: cfg_q.start_marker        <= cfg_data[7:0];
				REG_END_MARKER:   cfg_q.end_marker          <= cfg_data[7:0];
				REG_OPCODE_MASK0: cfg_q.opcode_mask[63:0]   <= cfg_data;
				REG_OPCODE_MASK1: cfg_q.opcode_mask[127:64] <= cfg_data;
				REG_OPCODE_MASK2: cfg_q.opcode_mask[191:128] <= cfg_data;
				REG_OPCODE_MASK3: cfg_q.opcode_mask[255:192] <= cfg_data;
				default: ;
			endcase
		end
	end

	fmr_front #(
		.MAX_STORED_PAYLOAD(MAX_STORED_PAYLOAD)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.rx_byte   (rx_byte),
		.back_busy (busy_any),
		.cmd_full  (cmd_full),
		.cmd_push  (cmd_push),
		.cmd       (push_cmd),
		.mem_wr    (mem_wr)
	);

	fmr_cmd_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.wr_cmd (push_cmd),
		.pop    (cmd_pop),
		.rd_cmd (pop_cmd),
		.full   (cmd_full),
		.empty  (cmd_empty)
	);

	fmr_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.mem_wr       (mem_wr),
		.cmd          (pop_cmd),
		.cmd_empty    (cmd_empty),
		.cmd_pop      (cmd_pop),
		.busy         (back_busy),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.frame_opcode (frame_opcode),
		.frame_length (frame_length),
		.byte_index   (byte_index),
		.payload_byte (payload_byte),
		.last         (last)
	);

	a_store_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		mem_wr.we |-> !busy_any)
		else $error("payload store written while a frame is being emitted");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_push |-> !cmd_full)
		else $error("command queue overflow");

	a_error_single: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != ST_GOOD) |-> (last && payload_byte == 8'd0
			&& byte_index == '0))
		else $error("error result is not a single zero result");

endmodule
